FILE: rtl/core/run_segment_blob_detector_unit_assert.svh
// Assertion macros for the run segment blob detector checker.
// Depends on nothing; included by the checker file.
`ifndef RUN_SEGMENT_BLOB_DETECTOR_UNIT_ASSERT_SVH
`define RUN_SEGMENT_BLOB_DETECTOR_UNIT_ASSERT_SVH

// same-cycle implication
`define RSBD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: check failed");

// next-cycle implication
`define RSBD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

FILE: rtl/core/rsbd_pkg.sv
// Types and constants of the run segment blob detector.
// No dependencies; used by rsbd_front, rsbd_queue, rsbd_back, the top level and the testbench.
`default_nettype none
package rsbd_pkg;

  localparam int MAX_ROWS = 1024;

  localparam logic [10:0] RST_WIDTH   = 11'd320;
  localparam logic [10:0] RST_HEIGHT  = 11'd240;
  localparam logic [7:0]  RST_MAX_GAP = 8'd2;
  localparam logic [10:0] RST_MIN_SEG = 11'd4;
  localparam logic [10:0] RST_MIN_H   = 11'd2;

  typedef enum logic [2:0] {
    REG_WIDTH   = 3'd0,
    REG_HEIGHT  = 3'd1,
    REG_MAX_GAP = 3'd2,
    REG_MIN_SEG = 3'd3,
    REG_MIN_H   = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [10:0] width;
    logic [10:0] height;
    logic [7:0]  max_gap;
    logic [10:0] min_seg;
    logic [10:0] min_h;
  } cfg_t;

  typedef struct packed {
    logic [9:0]  x;
    logic [9:0]  y;
    logic [10:0] w;
    logic [9:0]  h;
  } box_t;

  localparam int BOX_W = $bits(box_t);

  typedef struct packed {
    logic       seg_v;
    logic [9:0] s;
    logic [9:0] e;
    logic [9:0] row;
    logic       row_end;
    logic       frame_end;
  } ev_t;

  typedef struct packed {
    logic        blob_valid;
    logic [9:0]  x;
    logic [9:0]  y;
    logic [10:0] w;
    logic [9:0]  h;
    logic        frame_end;
    logic        last;
    logic        overflow;
  } res_t;

  typedef enum logic [2:0] {
    B_IDLE = 3'd0,
    B_RD   = 3'd1,
    B_PROC = 3'd2,
    B_END  = 3'd3,
    B_DONE = 3'd4
  } bstate_t;

  typedef enum logic [1:0] {
    M_SEG   = 2'd0,
    M_RET   = 2'd1,
    M_FLUSH = 2'd2
  } mode_t;

endpackage
`default_nettype wire

FILE: rtl/core/rsbd_if.sv
// Valid/ready channel interfaces for pixels in and boxes out.
// No dependencies.
`default_nettype none
interface rsbd_px_if;
  logic valid;
  logic ready;
  logic pixel_match;
  modport source (output valid, output pixel_match, input ready);
  modport sink (input valid, input pixel_match, output ready);
endinterface

interface rsbd_blob_if;
  logic        valid;
  logic        ready;
  logic        blob_valid;
  logic [9:0]  blob_x;
  logic [9:0]  blob_y;
  logic [10:0] blob_w;
  logic [9:0]  blob_h;
  logic        frame_end;
  logic        last_of_run;
  logic        overflow;
  modport source (output valid, output blob_valid, output blob_x, output blob_y,
                  output blob_w, output blob_h, output frame_end, output last_of_run,
                  output overflow, input ready);
  modport sink (input valid, input blob_valid, input blob_x, input blob_y,
                input blob_w, input blob_h, input frame_end, input last_of_run,
                input overflow, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/rsbd_ram.sv
// Generic single-write, single-read RAM with registered read.
// No dependencies.
`default_nettype none
module rsbd_ram #(
  parameter int WIDTH = 41,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]              rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

FILE: rtl/core/rsbd_front.sv
// Front end: per-pixel run detection, emits segment and row-end events.
// Depends on rsbd_pkg and rsbd_if.
`default_nettype none
module rsbd_front #(
  parameter int MAX_WIDTH = 1024
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  rsbd_px_if.sink            in_chan,
  input  wire rsbd_pkg::cfg_t cfg,
  input  wire logic          q_full,
  output logic               push,
  output rsbd_pkg::ev_t      push_ev
);
  logic [9:0] col_r, col_nxt, row_r, row_nxt, rs_r, rs_nxt;
  logic       ra_r, ra_nxt;
  logic [7:0] gc_r, gc_nxt;
  logic [12:0] wd;
  logic [10:0] ht;
  logic signed [13:0] endv;
  logic        accept, row_end, fe;
  rsbd_pkg::ev_t ev;

  assign in_chan.ready = !q_full;
  assign accept = in_chan.valid && !q_full;

  always_comb begin
    wd = {2'b0, cfg.width};
    if (wd == 13'd0) wd = 13'd1;
    if (wd > 13'(MAX_WIDTH)) wd = 13'(MAX_WIDTH);
    ht = cfg.height;
    if (ht == 11'd0) ht = 11'd1;
    if (ht > 11'(rsbd_pkg::MAX_ROWS)) ht = 11'(rsbd_pkg::MAX_ROWS);
  end

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    rs_nxt  = rs_r;
    ra_nxt  = ra_r;
    gc_nxt  = gc_r;
    ev      = '0;
    endv    = '0;
    ev.row  = row_r;
    ev.s    = rs_r;
    if (in_chan.pixel_match) begin
      if (!ra_r) begin
        ra_nxt = 1'b1;
        rs_nxt = col_r;
      end
      gc_nxt = '0;
    end else if (ra_r) begin
      if (gc_r >= cfg.max_gap) begin
        endv = $signed({4'b0, col_r}) - $signed({6'b0, cfg.max_gap});
        ev.seg_v = (endv - $signed({4'b0, rs_r})) >= $signed({3'b0, cfg.min_seg});
        ev.e = (endv < $signed({4'b0, rs_r})) ? rs_r : endv[9:0];
        ra_nxt = 1'b0;
        gc_nxt = '0;
      end else begin
        gc_nxt = gc_r + 8'd1;
      end
    end
    row_end = ({3'b0, col_r} + 13'd1) >= wd;
    fe = ({1'b0, row_r} + 11'd1) >= ht;
    if (row_end) begin
      ev.row_end   = 1'b1;
      ev.frame_end = fe;
      if (ra_nxt) begin
        endv = $signed({1'b0, wd}) - 14'sd1 - $signed({6'b0, gc_nxt});
        ev.seg_v = ($signed({1'b0, wd}) - $signed({4'b0, rs_nxt}))
                   >= $signed({3'b0, cfg.min_seg});
        ev.s = rs_nxt;
        ev.e = (endv < $signed({4'b0, rs_nxt})) ? rs_nxt : endv[9:0];
      end
      ra_nxt  = 1'b0;
      gc_nxt  = '0;
      col_nxt = '0;
      row_nxt = fe ? 10'd0 : row_r + 10'd1;
    end else begin
      col_nxt = col_r + 10'd1;
    end
  end

  assign push    = accept && (ev.seg_v || ev.row_end);
  assign push_ev = ev;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
      rs_r  <= '0;
      ra_r  <= 1'b0;
      gc_r  <= '0;
    end else if (accept) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      rs_r  <= rs_nxt;
      ra_r  <= ra_nxt;
      gc_r  <= gc_nxt;
    end
  end
endmodule
`default_nettype wire

FILE: rtl/core/rsbd_queue.sv
// Short event queue between the front and back ends.
// Depends on rsbd_pkg.
`default_nettype none
module rsbd_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire rsbd_pkg::ev_t push_ev,
  input  wire logic          pop,
  output rsbd_pkg::ev_t      head,
  output logic               empty,
  output logic               full
);
  localparam int DEPTH = 4;
  localparam int PW = $clog2(DEPTH);

  rsbd_pkg::ev_t   slot_r [DEPTH];
  logic [PW-1:0]   wp_r, rp_r;
  logic [PW:0]     cnt_r;

  assign empty = (cnt_r == '0);
  assign full  = (cnt_r == (PW+1)'(DEPTH));
  assign head  = slot_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wp_r] <= push_ev;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + PW'(1);
      if (pop) rp_r <= rp_r + PW'(1);
      cnt_r <= cnt_r + (PW+1)'(push) - (PW+1)'(pop);
    end
  end
endmodule
`default_nettype wire

FILE: rtl/core/rsbd_back.sv
// Back end: matches segments against the box table, retires and flushes boxes.
// Depends on rsbd_pkg, rsbd_if and rsbd_ram.
`default_nettype none
module rsbd_back #(
  parameter int MAX_BOXES = 32
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire rsbd_pkg::cfg_t cfg,
  input  wire logic           q_empty,
  input  wire rsbd_pkg::ev_t  q_head,
  output logic                q_pop,
  rsbd_blob_if.source         out_chan
);
  localparam int AW = $clog2(MAX_BOXES);
  localparam int CW = $clog2(MAX_BOXES + 1);

  typedef struct packed {
    logic [11:0] x;
    logic [11:0] w;
  } span_t;

  function automatic span_t span_add(logic [11:0] x, logic [11:0] w,
                                     logic [11:0] lo, logic [11:0] hi);
    span_t sp;
    sp.x = x;
    sp.w = w;
    if (lo < sp.x) begin
      sp.w = sp.w + (sp.x - lo);
      sp.x = lo;
    end
    if (hi > sp.x + sp.w) sp.w = hi - sp.x;
    return sp;
  endfunction

  rsbd_pkg::bstate_t st_r, st_nxt;
  rsbd_pkg::mode_t   mode_r, mode_nxt;
  rsbd_pkg::ev_t     ev_r, ev_nxt;
  rsbd_pkg::res_t    pend_r, pend_nxt, out_r, push_data, res;
  rsbd_pkg::box_t    d, wdata;
  logic [CW-1:0] r_r, r_nxt, w_r, w_nxt, cnt_r, cnt_nxt, m_r, m_nxt;
  logic [9:0]    mx_r, mx_nxt, my_r, my_nxt, mh_r, mh_nxt;
  logic [10:0]   mw_r, mw_nxt;
  logic found_r, found_nxt, any_r, any_nxt, ovf_r, ovf_nxt;
  logic pend_v_r, pend_v_nxt, out_v_r, out_v_nxt, push_out;
  logic we, ov, retire, emit_req, stall, can_push, at_end, need_marker, done_go;
  logic [AW-1:0] waddr;
  logic [rsbd_pkg::BOX_W-1:0] rdata;
  span_t sp_first, sp_merge;

  rsbd_ram #(.WIDTH(rsbd_pkg::BOX_W), .DEPTH(MAX_BOXES)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (r_r[AW-1:0]),
    .rdata (rdata)
  );

  assign d = rsbd_pkg::box_t'(rdata);
  assign can_push = !out_v_r || out_chan.ready;
  assign at_end = (r_r == cnt_r);
  assign ov = ({2'b0, ev_r.s} <= {2'b0, d.x}) ? (ev_r.e > d.x)
            : ({2'b0, ev_r.s} <= {2'b0, d.x} + {1'b0, d.w});
  assign retire = ({2'b0, d.y} + {2'b0, d.h} + {4'b0, cfg.max_gap}) < {2'b0, ev_r.row};
  assign sp_first = span_add({2'b0, d.x}, {1'b0, d.w}, {2'b0, ev_r.s}, {2'b0, ev_r.e});
  assign sp_merge = span_add({2'b0, mx_r}, {1'b0, mw_r}, {2'b0, d.x},
                             {2'b0, d.x} + {1'b0, d.w});

  always_comb begin
    case (mode_r)
      rsbd_pkg::M_RET:   emit_req = retire && ({1'b0, d.h} > cfg.min_h);
      rsbd_pkg::M_FLUSH: emit_req = 1'b1;
      default:           emit_req = 1'b0;
    endcase
  end

  assign stall = emit_req && pend_v_r && !can_push;
  assign need_marker = ev_r.frame_end && !any_r;
  assign done_go = !((need_marker || pend_v_r) && !can_push);

  always_comb begin
    res.blob_valid = 1'b1;
    res.x = d.x;
    res.y = d.y;
    res.w = d.w;
    res.h = d.h;
    res.frame_end = (mode_r == rsbd_pkg::M_FLUSH) || ev_r.frame_end;
    res.last = 1'b0;
    res.overflow = ovf_r;
  end

  // next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      rsbd_pkg::B_IDLE: if (!q_empty) st_nxt = rsbd_pkg::B_RD;
      rsbd_pkg::B_RD:   st_nxt = at_end ? rsbd_pkg::B_END : rsbd_pkg::B_PROC;
      rsbd_pkg::B_PROC: if (!stall) st_nxt = rsbd_pkg::B_RD;
      rsbd_pkg::B_END: begin
        if ((mode_r == rsbd_pkg::M_SEG && ev_r.row_end) ||
            (mode_r == rsbd_pkg::M_RET && ev_r.frame_end)) begin
          st_nxt = rsbd_pkg::B_RD;
        end else begin
          st_nxt = rsbd_pkg::B_DONE;
        end
      end
      rsbd_pkg::B_DONE: if (done_go) st_nxt = rsbd_pkg::B_IDLE;
      default: st_nxt = rsbd_pkg::B_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    mode_nxt   = mode_r;
    ev_nxt     = ev_r;
    r_nxt      = r_r;
    w_nxt      = w_r;
    cnt_nxt    = cnt_r;
    m_nxt      = m_r;
    mx_nxt     = mx_r;
    mw_nxt     = mw_r;
    my_nxt     = my_r;
    mh_nxt     = mh_r;
    found_nxt  = found_r;
    any_nxt    = any_r;
    ovf_nxt    = ovf_r;
    pend_v_nxt = pend_v_r;
    pend_nxt   = pend_r;
    q_pop      = 1'b0;
    we         = 1'b0;
    waddr      = w_r[AW-1:0];
    wdata      = d;
    push_out   = 1'b0;
    push_data  = pend_r;
    case (st_r)
      rsbd_pkg::B_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          ev_nxt    = q_head;
          mode_nxt  = q_head.seg_v ? rsbd_pkg::M_SEG : rsbd_pkg::M_RET;
          r_nxt     = '0;
          w_nxt     = '0;
          found_nxt = 1'b0;
          any_nxt   = 1'b0;
        end
      end
      rsbd_pkg::B_PROC: begin
        if (!stall) begin
          r_nxt = r_r + CW'(1);
          case (mode_r)
            rsbd_pkg::M_SEG: begin
              if (!found_r && ov) begin
                found_nxt = 1'b1;
                m_nxt  = w_r;
                my_nxt = d.y;
                mh_nxt = ev_r.row - d.y;
                mx_nxt = sp_first.x[9:0];
                mw_nxt = sp_first.w[10:0];
                w_nxt  = w_r + CW'(1);
              end else if (found_r && ov) begin
                mx_nxt = sp_merge.x[9:0];
                mw_nxt = sp_merge.w[10:0];
              end else begin
                we    = 1'b1;
                w_nxt = w_r + CW'(1);
              end
            end
            rsbd_pkg::M_RET: begin
              if (!retire) begin
                we    = 1'b1;
                w_nxt = w_r + CW'(1);
              end
            end
            default: ;
          endcase
          if (emit_req) begin
            any_nxt    = 1'b1;
            pend_v_nxt = 1'b1;
            pend_nxt   = res;
            if (pend_v_r) push_out = 1'b1;
          end
        end
      end
      rsbd_pkg::B_END: begin
        case (mode_r)
          rsbd_pkg::M_SEG: begin
            if (found_r) begin
              we      = 1'b1;
              waddr   = m_r[AW-1:0];
              wdata   = '{x: mx_r, y: my_r, w: mw_r, h: mh_r};
              cnt_nxt = w_r;
            end else if (cnt_r < CW'(MAX_BOXES)) begin
              we      = 1'b1;
              waddr   = cnt_r[AW-1:0];
              wdata   = '{x: ev_r.s, y: ev_r.row, w: {1'b0, ev_r.e - ev_r.s}, h: 10'd1};
              cnt_nxt = cnt_r + CW'(1);
            end else begin
              ovf_nxt = 1'b1;
            end
            if (ev_r.row_end) begin
              mode_nxt = rsbd_pkg::M_RET;
              r_nxt    = '0;
              w_nxt    = '0;
            end
          end
          rsbd_pkg::M_RET: begin
            cnt_nxt = w_r;
            if (ev_r.frame_end) begin
              mode_nxt = rsbd_pkg::M_FLUSH;
              r_nxt    = '0;
            end
          end
          default: cnt_nxt = '0;
        endcase
      end
      rsbd_pkg::B_DONE: begin
        if (can_push) begin
          if (need_marker) begin
            push_out  = 1'b1;
            push_data = '{blob_valid: 1'b0, x: '0, y: '0, w: '0, h: '0,
                          frame_end: 1'b1, last: 1'b1, overflow: ovf_r};
          end else if (pend_v_r) begin
            push_out       = 1'b1;
            push_data.last = 1'b1;
            pend_v_nxt     = 1'b0;
          end
        end
        if (done_go && ev_r.frame_end) ovf_nxt = 1'b0;
      end
      default: ;
    endcase
  end

  always_comb begin
    out_v_nxt = out_v_r && !out_chan.ready;
    if (push_out) out_v_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= rsbd_pkg::B_IDLE;
      mode_r   <= rsbd_pkg::M_SEG;
      r_r      <= '0;
      w_r      <= '0;
      cnt_r    <= '0;
      found_r  <= 1'b0;
      any_r    <= 1'b0;
      ovf_r    <= 1'b0;
      pend_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      st_r     <= st_nxt;
      mode_r   <= mode_nxt;
      r_r      <= r_nxt;
      w_r      <= w_nxt;
      cnt_r    <= cnt_nxt;
      found_r  <= found_nxt;
      any_r    <= any_nxt;
      ovf_r    <= ovf_nxt;
      pend_v_r <= pend_v_nxt;
      out_v_r  <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ev_r   <= ev_nxt;
    m_r    <= m_nxt;
    mx_r   <= mx_nxt;
    mw_r   <= mw_nxt;
    my_r   <= my_nxt;
    mh_r   <= mh_nxt;
    pend_r <= pend_nxt;
    if (push_out) out_r <= push_data;
  end

  assign out_chan.valid       = out_v_r;
  assign out_chan.blob_valid  = out_r.blob_valid;
  assign out_chan.blob_x      = out_r.x;
  assign out_chan.blob_y      = out_r.y;
  assign out_chan.blob_w      = out_r.w;
  assign out_chan.blob_h      = out_r.h;
  assign out_chan.frame_end   = out_r.frame_end;
  assign out_chan.last_of_run = out_r.last;
  assign out_chan.overflow    = out_r.overflow;
endmodule
`default_nettype wire

FILE: rtl/core/run_segment_blob_detector_unit.sv
// Run detection keeps pace at one pixel per clock while the event queue has room.
// Events queue (depth 4) ahead of the box table engine, which walks the table for each event; a row
// end that also closes a segment adds a retire pass, a frame end adds a flush pass, and
// result-channel stalls lengthen both. The pixel side stalls only when the event queue is full.
// Reset: synchronous active-low rst_n clears counters, box count and flags; box RAM not cleared.
`default_nettype none
module run_segment_blob_detector_unit #(
  parameter int MAX_WIDTH = 1024,
  parameter int MAX_BOXES = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  rsbd_px_if.sink          in_chan,
  rsbd_blob_if.source      out_chan,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  rsbd_pkg::cfg_t cfg_r;
  rsbd_pkg::ev_t  push_ev, q_head;
  rsbd_pkg::reg_idx_t widx;
  logic push, q_full, q_empty, q_pop;

  assign pready = 1'b1;
  assign widx = rsbd_pkg::reg_idx_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.width   <= rsbd_pkg::RST_WIDTH;
      cfg_r.height  <= rsbd_pkg::RST_HEIGHT;
      cfg_r.max_gap <= rsbd_pkg::RST_MAX_GAP;
      cfg_r.min_seg <= rsbd_pkg::RST_MIN_SEG;
      cfg_r.min_h   <= rsbd_pkg::RST_MIN_H;
    end else if (psel && penable && pwrite) begin
      case (widx)
        rsbd_pkg::REG_WIDTH:   cfg_r.width   <= pwdata[10:0];
        rsbd_pkg::REG_HEIGHT:  cfg_r.height  <= pwdata[10:0];
        rsbd_pkg::REG_MAX_GAP: cfg_r.max_gap <= pwdata[7:0];
        rsbd_pkg::REG_MIN_SEG: cfg_r.min_seg <= pwdata[10:0];
        rsbd_pkg::REG_MIN_H:   cfg_r.min_h   <= pwdata[10:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (widx)
      rsbd_pkg::REG_WIDTH:   prdata = {21'b0, cfg_r.width};
      rsbd_pkg::REG_HEIGHT:  prdata = {21'b0, cfg_r.height};
      rsbd_pkg::REG_MAX_GAP: prdata = {24'b0, cfg_r.max_gap};
      rsbd_pkg::REG_MIN_SEG: prdata = {21'b0, cfg_r.min_seg};
      rsbd_pkg::REG_MIN_H:   prdata = {21'b0, cfg_r.min_h};
      default:               prdata = '0;
    endcase
  end

  rsbd_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .cfg     (cfg_r),
    .q_full  (q_full),
    .push    (push),
    .push_ev (push_ev)
  );

  rsbd_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_ev (push_ev),
    .pop     (q_pop),
    .head    (q_head),
    .empty   (q_empty),
    .full    (q_full)
  );

  rsbd_back #(.MAX_BOXES(MAX_BOXES)) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .q_empty  (q_empty),
    .q_head   (q_head),
    .q_pop    (q_pop),
    .out_chan (out_chan)
  );
endmodule
`default_nettype wire

FILE: rtl/core/rsbd_port_chk.sv
// Port-level checker for the blob detector result channel, bound to the top level.
// Depends on run_segment_blob_detector_unit_assert.svh.
`default_nettype none
`include "run_segment_blob_detector_unit_assert.svh"
module rsbd_port_chk (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic        blob_valid,
  input wire logic [9:0]  blob_x,
  input wire logic [9:0]  blob_y,
  input wire logic [10:0] blob_w,
  input wire logic [9:0]  blob_h,
  input wire logic        frame_end,
  input wire logic        last_of_run
);
  `RSBD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
  `RSBD_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && !out_ready, $stable(blob_x) && $stable(blob_y) && $stable(blob_w) && $stable(blob_h) && $stable(blob_valid))
  `RSBD_ASSERT_NOW(a_marker, clk, rst_n, out_valid && !blob_valid, frame_end && last_of_run && blob_x == 10'd0 && blob_y == 10'd0 && blob_w == 11'd0 && blob_h == 10'd0)
  `RSBD_ASSERT_NOW(a_retired_h, clk, rst_n, out_valid && blob_valid && !frame_end, blob_h != 10'd0)
endmodule

bind run_segment_blob_detector_unit rsbd_port_chk u_rsbd_port_chk (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_chan.valid),
  .out_ready   (out_chan.ready),
  .blob_valid  (out_chan.blob_valid),
  .blob_x      (out_chan.blob_x),
  .blob_y      (out_chan.blob_y),
  .blob_w      (out_chan.blob_w),
  .blob_h      (out_chan.blob_h),
  .frame_end   (out_chan.frame_end),
  .last_of_run (out_chan.last_of_run)
);
`default_nettype wire

FILE: sim/tb_run_segment_blob_detector_unit.sv
// Testbench for run_segment_blob_detector_unit: drives pixel frames under bursty traffic
// and receiver stalls, predicts the box stream, and checks it transaction by transaction.
// Depends on rsbd_pkg, rsbd_if and the unit itself.
`default_nettype none
module tb_run_segment_blob_detector_unit;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  rsbd_px_if   px_if();
  rsbd_blob_if blob_if();

  initial begin
    px_if.valid = 1'b0;
    px_if.pixel_match = 1'b0;
    blob_if.ready = 1'b0;
  end

  run_segment_blob_detector_unit dut (
    .clk(clk), .rst_n(rst_n), .in_chan(px_if.sink), .out_chan(blob_if.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // shadow registers and box tracker state
  int c_w, c_h, c_gap, c_minseg, c_minh;
  int col, row, run_act, run_st, gap, nbox, ovf;
  int bx[32], by[32], bw[32], bh[32];
  rsbd_pkg::res_t boxes_due[$];
  logic pend_px[$];
  int mismatches = 0;
  int idle_left = 0, burst_left = 8;
  int stall_mode = 0, stall_left = 0;

  function automatic bit hits(int s, int e, int i);
    if (s <= bx[i]) return e > bx[i];
    return s <= bx[i] + bw[i];
  endfunction

  function automatic void drop_box(int i);
    for (int k = i; k + 1 < nbox; k++) begin
      bx[k] = bx[k+1]; by[k] = by[k+1]; bw[k] = bw[k+1]; bh[k] = bh[k+1];
    end
    nbox--;
  endfunction

  function automatic void place_segment(int s, int e, int y);
    int m, i, mx, mw;
    for (m = 0; m < nbox; m++) if (hits(s, e, m)) break;
    if (m == nbox) begin
      if (nbox < 32) begin
        bx[nbox] = s; by[nbox] = y; bw[nbox] = e - s; bh[nbox] = 1; nbox++;
      end else ovf = 1;
      return;
    end
    bh[m] = (y - by[m]) & 1023;
    mx = bx[m];
    mw = bw[m];
    if (s < mx) begin mw += mx - s; mx = s; end
    if (e > mx + mw) mw = e - mx;
    i = m + 1;
    while (i < nbox) begin
      if (hits(s, e, i)) begin
        if (mx > bx[i]) begin mw += mx - bx[i]; mx = bx[i]; end
        if (mx + mw < bx[i] + bw[i]) mw = bx[i] + bw[i] - mx;
        drop_box(i);
      end else i++;
    end
    bx[m] = mx;
    bw[m] = mw;
  endfunction

  function automatic void close_run(int e, bit keep);
    if (e < run_st) e = run_st;
    if (keep) place_segment(run_st, e, row);
    run_act = 0;
    gap = 0;
  endfunction

  function automatic void add_box(ref rsbd_pkg::res_t q[$], input bit v, input int x,
                                  input int y, input int w, input int h, input bit fe);
    rsbd_pkg::res_t r;
    if (q.size() >= 32) return;
    r = '{blob_valid: v, x: x[9:0], y: y[9:0], w: w[10:0], h: h[9:0],
          frame_end: fe, last: 1'b0, overflow: ovf[0]};
    q = {q, r};
  endfunction

  function automatic void track_pixel(logic px);
    int wd, ht, e, i;
    bit fe;
    rsbd_pkg::res_t q[$];
    wd = (c_w < 1) ? 1 : (c_w > 1024) ? 1024 : c_w;
    ht = (c_h < 1) ? 1 : (c_h > 1024) ? 1024 : c_h;
    if (px) begin
      if (!run_act) begin run_act = 1; run_st = col; end
      gap = 0;
    end else if (run_act) begin
      if (gap >= c_gap) begin
        e = col - c_gap;
        close_run(e, e - run_st >= c_minseg);
      end else gap++;
    end
    if (col + 1 < wd) begin
      col = (col + 1) & 1023;
      return;
    end
    fe = (row + 1 >= ht);
    if (run_act) close_run(wd - 1 - gap, wd - run_st >= c_minseg);
    i = 0;
    while (i < nbox) begin
      if (by[i] + bh[i] + c_gap < row) begin
        if (bh[i] > c_minh) add_box(q, 1'b1, bx[i], by[i], bw[i], bh[i], fe);
        drop_box(i);
      end else i++;
    end
    if (fe) begin
      for (i = 0; i < nbox; i++) add_box(q, 1'b1, bx[i], by[i], bw[i], bh[i], 1'b1);
      if (q.size() == 0) add_box(q, 1'b0, 0, 0, 0, 0, 1'b1);
      nbox = 0; ovf = 0; row = 0;
    end else row = (row + 1) & 1023;
    col = 0; run_act = 0; gap = 0;
    if (q.size() > 0) q[q.size()-1].last = 1'b1;
    boxes_due = {boxes_due, q};
  endfunction

  // pixel driver
  always @(posedge clk) begin
    if (!rst_n) px_if.valid <= 1'b0;
    else if (!px_if.valid || px_if.ready) begin
      if (px_if.valid) track_pixel(px_if.pixel_match);
      if (idle_left > 0) begin
        idle_left--;
        px_if.valid <= 1'b0;
      end else if (pend_px.size() > 0) begin
        px_if.valid <= 1'b1;
        px_if.pixel_match <= pend_px.pop_front();
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 40);
          idle_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else px_if.valid <= 1'b0;
    end
  end

  // box monitor and receiver stalls
  always @(posedge clk) begin
    rsbd_pkg::res_t got, want;
    if (!rst_n) blob_if.ready <= 1'b0;
    else begin
      if (blob_if.valid && blob_if.ready) begin
        got = '{blob_valid: blob_if.blob_valid, x: blob_if.blob_x, y: blob_if.blob_y,
                w: blob_if.blob_w, h: blob_if.blob_h, frame_end: blob_if.frame_end,
                last: blob_if.last_of_run, overflow: blob_if.overflow};
        if (boxes_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected transaction: %p", got);
        end else begin
          want = boxes_due.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch: expected %p got %p", want, got);
          end
        end
      end
      if (stall_left <= 0) begin
        stall_mode = $urandom_range(0, 2);
        stall_left = $urandom_range(20, 300);
      end
      stall_left--;
      case (stall_mode)
        0: blob_if.ready <= 1'b1;
        1: blob_if.ready <= ($urandom_range(0, 1) == 1);
        default: blob_if.ready <= ($urandom_range(0, 9) == 0);
      endcase
    end
  end

  task automatic write_reg(rsbd_pkg::reg_idx_t idx, int val);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= 5'(idx * 4); pwdata <= 32'(val);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      rsbd_pkg::REG_WIDTH:   c_w = val & 11'h7FF;
      rsbd_pkg::REG_HEIGHT:  c_h = val & 11'h7FF;
      rsbd_pkg::REG_MAX_GAP: c_gap = val & 8'hFF;
      rsbd_pkg::REG_MIN_SEG: c_minseg = val & 11'h7FF;
      default:               c_minh = val & 11'h7FF;
    endcase
  endtask

  task automatic wait_idle();
    wait (pend_px.size() == 0 && !px_if.valid && boxes_due.size() == 0);
    repeat (200) @(posedge clk);
  endtask

  task automatic setup(int w, int h, int g, int ms, int mh);
    wait_idle();
    write_reg(rsbd_pkg::REG_WIDTH, w);
    write_reg(rsbd_pkg::REG_HEIGHT, h);
    write_reg(rsbd_pkg::REG_MAX_GAP, g);
    write_reg(rsbd_pkg::REG_MIN_SEG, ms);
    write_reg(rsbd_pkg::REG_MIN_H, mh);
  endtask

  // kind 0: rectangles with light noise, 1: pure noise, 2: alternating, 3: sparse
  task automatic queue_frame(int w, int h, int kind);
    int rx[4], ry[4], rw[4], rh[4], nr;
    logic p;
    nr = $urandom_range(1, 4);
    for (int r = 0; r < nr; r++) begin
      rx[r] = $urandom_range(0, w - 1); rw[r] = $urandom_range(1, w);
      ry[r] = $urandom_range(0, h - 1); rh[r] = $urandom_range(1, h);
    end
    for (int y = 0; y < h; y++)
      for (int x = 0; x < w; x++) begin
        p = 1'b0;
        case (kind)
          0: begin
            for (int r = 0; r < nr; r++)
              if (x >= rx[r] && x < rx[r] + rw[r] && y >= ry[r] && y < ry[r] + rh[r]) p = 1'b1;
            if ($urandom_range(0, 15) == 0) p = ~p;
          end
          1: p = $urandom_range(0, 1);
          2: p = ~x[0];
          default: p = ($urandom_range(0, 63) == 0);
        endcase
        pend_px = {pend_px, p};
      end
  endtask

  initial begin
    int w, h, sent;
    c_w = rsbd_pkg::RST_WIDTH; c_h = rsbd_pkg::RST_HEIGHT; c_gap = rsbd_pkg::RST_MAX_GAP;
    c_minseg = rsbd_pkg::RST_MIN_SEG; c_minh = rsbd_pkg::RST_MIN_H;
    col = 0; row = 0; run_act = 0; run_st = 0; gap = 0; nbox = 0; ovf = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed: tiny frames, full-width runs, table overflow, register extremes
    setup(4, 3, 0, 0, 0);
    pend_px = '{1,1,1,1, 0,0,0,0, 1,0,1,1};
    setup(0, 0, 0, 0, 0);
    pend_px = '{1, 0};
    setup(80, 1, 0, 0, 0);
    queue_frame(80, 1, 2);
    setup(60, 1, 255, 1024, 1024);
    queue_frame(60, 1, 1);
    setup(1, 40, 255, 0, 1024);
    queue_frame(1, 40, 3);
    setup(32, 2, 1, 1024, 0);
    queue_frame(32, 2, 0);

    sent = 258;
    while (sent < 430) begin
      w = $urandom_range(4, 16);
      h = $urandom_range(2, 6);
      setup(w, h, $urandom_range(0, 3), $urandom_range(0, 5), $urandom_range(0, 3));
      for (int f = 0; f < 2; f++) begin
        queue_frame(w, h, ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0);
        sent += w * h;
      end
    end

    wait_idle();
    if (mismatches == 0 && boxes_due.size() == 0)
      $display("tb_run_segment_blob_detector_unit: clean");
    else
      $display("tb_run_segment_blob_detector_unit: errors");
    $finish;
  end

  initial begin
    #6_000_000;
    $display("tb_run_segment_blob_detector_unit: errors");
    $finish;
  end
endmodule
`default_nettype wire
